@@ hw/rtl/lacc_pkg.sv @@
// ----------------------------------------------------------------------------
// lacc_pkg
// shared types and constants of the lattice action cost checker
// ----------------------------------------------------------------------------
package lacc_pkg;

  // map geometry, side is a power of two
  localparam int unsigned MAP_SIDE  = 256;
  localparam int unsigned COORD_W   = $clog2(MAP_SIDE);
  localparam int unsigned ADDR_W    = 2 * COORD_W;
  localparam int unsigned MAP_DEPTH = MAP_SIDE * MAP_SIDE;

  // largest usable map dimension in the 9-bit size registers
  localparam int unsigned DIM_MAX = (MAP_SIDE > 511) ? 511 : MAP_SIDE;
  localparam logic [8:0]  DIM_CAP = 9'(DIM_MAX);

  // base cost width in use
  localparam int unsigned COST_BITS = 16;
  localparam logic [15:0] BASE_MASK =
    (COST_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << COST_BITS) - 32'd1);

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_MAP_WIDTH  = 2'd0,
    REG_MAP_HEIGHT = 2'd1,
    REG_INSCRIBED  = 2'd2,
    REG_OBSTACLE   = 2'd3
  } reg_idx_e;

  // evaluate item on its way through the read stages
  typedef struct packed {
    logic        present;
    logic        last;
    logic [15:0] base;
    logic        src_ok;
    logic        end_ok;
    logic        step_ok;
  } item_t;

  // closed action waiting for the multiply
  typedef struct packed {
    logic        blocked;
    logic [15:0] base;
    logic [8:0]  scale;
  } res_t;

endpackage

@@ hw/rtl/lacc_acc.sv @@
// ----------------------------------------------------------------------------
// lacc_acc
// per-action accumulation: blocking checks and running maximum of cell costs
// ----------------------------------------------------------------------------
module lacc_acc (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  lacc_pkg::item_t item_i,
  input  logic [7:0]     src_cost_i,
  input  logic [7:0]     end_cost_i,
  input  logic [7:0]     step_cost_i,
  input  logic [7:0]     inscribed_i,
  input  logic [7:0]     obstacle_i,
  output logic           res_valid_o,
  output lacc_pkg::res_t res_o
);
  import lacc_pkg::*;

  logic [7:0] running_max_q, running_max_d;
  logic       blocked_q, blocked_d;

  logic       item_blk;
  logic       blk_pre;
  logic       blk_post;
  logic [7:0] rm;
  logic [7:0] m_all;

  always_comb begin
    item_blk = !item_i.src_ok || !item_i.end_ok ||
               (src_cost_i >= obstacle_i) || (end_cost_i >= obstacle_i) ||
               (end_cost_i >= inscribed_i);
    blk_pre  = blocked_q || item_blk;
    blk_post = blk_pre;
    rm       = running_max_q;
    if (!blk_pre && item_i.present) begin
      if (!item_i.step_ok) begin
        blk_post = 1'b1;
      end else begin
        if (step_cost_i > rm) begin
          rm = step_cost_i;
        end
        if (rm >= inscribed_i) begin
          blk_post = 1'b1;
        end
      end
    end
    m_all = rm;
    if (src_cost_i > m_all) begin
      m_all = src_cost_i;
    end
    if (end_cost_i > m_all) begin
      m_all = end_cost_i;
    end
  end

  always_comb begin
    running_max_d = running_max_q;
    blocked_d     = blocked_q;
    if (step_i) begin
      if (item_i.last) begin
        running_max_d = '0;
        blocked_d     = 1'b0;
      end else begin
        running_max_d = rm;
        blocked_d     = blk_post;
      end
    end
  end

  assign res_valid_o   = step_i && item_i.last;
  assign res_o.blocked = blk_post;
  assign res_o.base    = blk_post ? 16'd0 : item_i.base;
  assign res_o.scale   = {1'b0, m_all} + 9'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_max_q <= '0;
      blocked_q     <= 1'b0;
    end else begin
      running_max_q <= running_max_d;
      blocked_q     <= blocked_d;
    end
  end

endmodule

@@ hw/rtl/lattice_action_cost_check_top.sv @@
// ----------------------------------------------------------------------------
// lattice_action_cost_check_top
// cost map with motion primitive cost evaluation
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_stall_o): one word is either a map cell
//   write or one evaluate item of an action; an action closes on last = 1
//   output channel (out_valid_o / out_stall_i): one word per closed action,
//   action cost and blocked flag
//   config channel (cfg_valid_i / cfg_ready_o): register index and data,
//   always ready, write only while no action is in flight
// throughput: an evaluate word reads three map cells and the map memory has
//   two read ports, so it stalls the input for a second read; map writes
//   every cycle unless stalled; result path: read, accumulate, product, output
// reset: size and threshold registers go to their defaults, the pipeline
//   empties; map cells hold no value until written
// stall: the output register holds its word, the pipeline fills behind it
//   and in_stall_o rises; no word is dropped
// ----------------------------------------------------------------------------
module lattice_action_cost_check_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        in_command_i,
  input  logic [7:0]  in_map_x_i,
  input  logic [7:0]  in_map_y_i,
  input  logic [7:0]  in_cell_value_i,
  input  logic [7:0]  in_end_dx_i,
  input  logic [7:0]  in_end_dy_i,
  input  logic [7:0]  in_step_dx_i,
  input  logic [7:0]  in_step_dy_i,
  input  logic        in_step_present_i,
  input  logic [15:0] in_base_cost_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [23:0] out_action_cost_o,
  output logic        out_blocked_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i
);
  import lacc_pkg::*;

  function automatic logic on_map(logic [9:0] pos, logic [8:0] dim);
    return !pos[9] && (pos[8:0] < dim);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(logic [8:0] x, logic [8:0] y);
    return {COORD_W'(y), COORD_W'(x)};
  endfunction

  // configuration
  logic [8:0] width_q, height_q;
  logic [7:0] inscribed_q, obstacle_q;
  logic [8:0] eff_w, eff_h;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= 9'd256;
      height_q    <= 9'd256;
      inscribed_q <= 8'd253;
      obstacle_q  <= 8'd254;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_MAP_WIDTH:  width_q     <= cfg_data_i;
        REG_MAP_HEIGHT: height_q    <= cfg_data_i;
        REG_INSCRIBED:  inscribed_q <= cfg_data_i[7:0];
        REG_OBSTACLE:   obstacle_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign eff_w = (width_q > DIM_CAP) ? DIM_CAP : width_q;
  assign eff_h = (height_q > DIM_CAP) ? DIM_CAP : height_q;

  // handshake and pipeline control
  logic  s1_v_q, s2_v_q, p_v_q, out_v_q;
  logic  s2_adv, p_adv, s2_hold;
  logic  accept, accept_eval, accept_write;
  item_t s1_item_q, s2_item_q, in_item;
  logic  res_valid;
  res_t  res, p_res_q;

  assign p_adv   = p_v_q && (!out_v_q || !out_stall_i);
  assign s2_hold = s2_v_q && p_v_q && !p_adv;
  assign s2_adv  = s2_v_q && !s2_hold;

  assign in_stall_o   = s1_v_q || s2_hold;
  assign accept       = in_valid_i && !in_stall_o;
  assign accept_eval  = accept && (cmd_e'(in_command_i) == CMD_EVAL);
  assign accept_write = accept && (cmd_e'(in_command_i) == CMD_WRITE);

  // cell positions, 10-bit two's complement
  logic [9:0] src_x, src_y, end_x, end_y, stp_x, stp_y;

  assign src_x = {2'b00, in_map_x_i};
  assign src_y = {2'b00, in_map_y_i};
  assign end_x = src_x + {{2{in_end_dx_i[7]}}, in_end_dx_i};
  assign end_y = src_y + {{2{in_end_dy_i[7]}}, in_end_dy_i};
  assign stp_x = src_x + {{2{in_step_dx_i[7]}}, in_step_dx_i};
  assign stp_y = src_y + {{2{in_step_dy_i[7]}}, in_step_dy_i};

  always_comb begin
    in_item.present = in_step_present_i;
    in_item.last    = in_last_i;
    in_item.base    = in_base_cost_i & BASE_MASK;
    in_item.src_ok  = on_map(src_x, eff_w) && on_map(src_y, eff_h);
    in_item.end_ok  = on_map(end_x, eff_w) && on_map(end_y, eff_h);
    in_item.step_ok = on_map(stp_x, eff_w) && on_map(stp_y, eff_h);
  end

  // cost map: one write port, two read ports
  logic [7:0]        cost_map [MAP_DEPTH];
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_a_addr, rd_b_addr, end_addr_q;
  logic              rd_a_en;
  logic [7:0]        rd_a_q, rd_b_q, src_cost_q;

  assign wr_en     = accept_write && ({1'b0, in_map_x_i} < DIM_CAP) &&
                     ({1'b0, in_map_y_i} < DIM_CAP);
  assign wr_addr   = cell_addr({1'b0, in_map_x_i}, {1'b0, in_map_y_i});
  assign rd_a_en   = accept_eval || s1_v_q;
  assign rd_a_addr = s1_v_q ? end_addr_q : cell_addr(src_x[8:0], src_y[8:0]);
  assign rd_b_addr = cell_addr(stp_x[8:0], stp_y[8:0]);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cost_map[wr_addr] <= in_cell_value_i;
    end
    if (rd_a_en) begin
      rd_a_q <= cost_map[rd_a_addr];
    end
    if (accept_eval) begin
      rd_b_q <= cost_map[rd_b_addr];
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (accept_eval) begin
      s1_item_q  <= in_item;
      end_addr_q <= cell_addr(end_x[8:0], end_y[8:0]);
    end
    if (s1_v_q) begin
      s2_item_q  <= s1_item_q;
      src_cost_q <= rd_a_q;
    end
    if (res_valid) begin
      p_res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      p_v_q  <= 1'b0;
    end else begin
      s1_v_q <= accept_eval;
      if (s1_v_q) begin
        s2_v_q <= 1'b1;
      end else if (s2_adv) begin
        s2_v_q <= 1'b0;
      end
      if (res_valid) begin
        p_v_q <= 1'b1;
      end else if (p_adv) begin
        p_v_q <= 1'b0;
      end
    end
  end

  lacc_acc u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (s2_adv),
    .item_i      (s2_item_q),
    .src_cost_i  (src_cost_q),
    .end_cost_i  (rd_a_q),
    .step_cost_i (rd_b_q),
    .inscribed_i (inscribed_q),
    .obstacle_i  (obstacle_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // multiply into the output register
  logic [24:0] product;
  logic [23:0] out_cost_q;
  logic        out_blocked_q;

  assign product = 25'(p_res_q.base) * 25'(p_res_q.scale);

  always_ff @(posedge clk_i) begin
    if (p_adv) begin
      out_cost_q    <= p_res_q.blocked ? 24'd0 : product[23:0];
      out_blocked_q <= p_res_q.blocked;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (p_adv) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_v_q;
  assign out_action_cost_o = out_cost_q;
  assign out_blocked_o     = out_blocked_q;

endmodule

@@ hw/rtl/lacc_checker.sv @@
// ----------------------------------------------------------------------------
// lacc_checker
// port-level checks of the lattice action cost checker
// ----------------------------------------------------------------------------
module lacc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        in_command_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [23:0] out_action_cost_o,
  input logic        out_blocked_o
);
  import lacc_pkg::*;

  // in_stall_o rises after every accepted evaluate word
  a_in_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_e'(in_command_i) == CMD_EVAL) |=> in_stall_o)
    else $error("evaluate word accepted on consecutive cycles");

  // a blocked action carries no cost
  a_blocked_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_blocked_o |-> out_action_cost_o == 24'd0)
    else $error("blocked action with nonzero cost");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid after reset");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_action_cost_o) &&
      $stable(out_blocked_o))
    else $error("stalled output word changed");

endmodule

bind lattice_action_cost_check_top lacc_checker u_lacc_checker (.*);

@@ tb/lacc_cost_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lacc_cost_checker
// watches the map/action, result and register channels of the action cost
// checker, keeps its own copy of the cost map and registers, predicts the
// cost word of every closed action and compares it field by field
// ----------------------------------------------------------------------------
module lacc_cost_checker
  import lacc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        in_command_i,
  input  logic [7:0]  in_map_x_i,
  input  logic [7:0]  in_map_y_i,
  input  logic [7:0]  in_cell_value_i,
  input  logic [7:0]  in_end_dx_i,
  input  logic [7:0]  in_end_dy_i,
  input  logic [7:0]  in_step_dx_i,
  input  logic [7:0]  in_step_dy_i,
  input  logic        in_step_present_i,
  input  logic [15:0] in_base_cost_i,
  input  logic        in_last_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [23:0] out_action_cost_i,
  input  logic        out_blocked_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [8:0]  cfg_data_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned results_o,
  output int unsigned blocked_o
);

  typedef struct packed {
    logic [23:0] cost;
    logic        blocked;
  } action_result_t;

  action_result_t awaited_costs[$];

  bit   [7:0] cost_map [MAP_DEPTH];
  logic [8:0] map_width_q;
  logic [8:0] map_height_q;
  logic [7:0] inscribed_q;
  logic [7:0] obstacle_q;
  logic [7:0] worst_step_q;
  logic       action_blocked_q;

  function automatic int clip_dim(logic [8:0] d);
    return (int'(d) > int'(MAP_SIDE)) ? int'(MAP_SIDE) : int'(d);
  endfunction

  function automatic bit on_map(int x, int y);
    return x >= 0 && y >= 0 && x < clip_dim(map_width_q) && y < clip_dim(map_height_q);
  endfunction

  function automatic logic [7:0] cost_at(int x, int y);
    return cost_map[(y * int'(MAP_SIDE) + x) & int'(MAP_DEPTH - 1)];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int             sx, sy, ex, ey, px, py;
    logic     [7:0] worst;
    logic    [31:0] product;
    action_result_t want;
    if (!rst_ni) begin
      map_width_q      = 9'd256;
      map_height_q     = 9'd256;
      inscribed_q      = 8'd253;
      obstacle_q       = 8'd254;
      worst_step_q     = 8'd0;
      action_blocked_q = 1'b0;
      awaited_costs.delete();
      fail_count_o     = 0;
      results_o        = 0;
      blocked_o        = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_MAP_WIDTH:  map_width_q  = cfg_data_i;
          REG_MAP_HEIGHT: map_height_q = cfg_data_i;
          REG_INSCRIBED:  inscribed_q  = cfg_data_i[7:0];
          REG_OBSTACLE:   obstacle_q   = cfg_data_i[7:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        sx = int'(in_map_x_i);
        sy = int'(in_map_y_i);
        ex = sx + int'($signed(in_end_dx_i));
        ey = sy + int'($signed(in_end_dy_i));
        px = sx + int'($signed(in_step_dx_i));
        py = sy + int'($signed(in_step_dy_i));
        if (cmd_e'(in_command_i) == CMD_WRITE) begin
          cost_map[sy * int'(MAP_SIDE) + sx] = in_cell_value_i;
        end else begin
          if (!(on_map(sx, sy) && cost_at(sx, sy) < obstacle_q) ||
              !(on_map(ex, ey) && cost_at(ex, ey) < obstacle_q) ||
              cost_at(ex, ey) >= inscribed_q) begin
            action_blocked_q = 1'b1;
          end
          if (!action_blocked_q && in_step_present_i) begin
            if (!on_map(px, py)) begin
              action_blocked_q = 1'b1;
            end else begin
              if (cost_at(px, py) > worst_step_q) worst_step_q = cost_at(px, py);
              if (worst_step_q >= inscribed_q) action_blocked_q = 1'b1;
            end
          end
          if (in_last_i) begin
            if (action_blocked_q) begin
              want = '{cost: 24'd0, blocked: 1'b1};
            end else begin
              worst = worst_step_q;
              if (cost_at(sx, sy) > worst) worst = cost_at(sx, sy);
              if (cost_at(ex, ey) > worst) worst = cost_at(ex, ey);
              product = 32'(in_base_cost_i & BASE_MASK) * (32'(worst) + 32'd1);
              want = '{cost: product[23:0], blocked: 1'b0};
            end
            awaited_costs.push_back(want);
            worst_step_q     = 8'd0;
            action_blocked_q = 1'b0;
          end
        end
      end

      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (out_blocked_i) blocked_o++;
        if (awaited_costs.size() == 0) begin
          $display("%t unexpected result word: expected none, actual cost %0d blocked %0b",
                   $time, out_action_cost_i, out_blocked_i);
          fail_count_o++;
        end else begin
          want = awaited_costs.pop_front();
          if (out_action_cost_i !== want.cost) begin
            $display("%t action_cost mismatch: expected %0d actual %0d",
                     $time, want.cost, out_action_cost_i);
            fail_count_o++;
          end
          if (out_blocked_i !== want.blocked) begin
            $display("%t blocked mismatch: expected %0b actual %0b",
                     $time, want.blocked, out_blocked_i);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = awaited_costs.size();
  end

endmodule

@@ tb/lattice_action_cost_check_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lattice_action_cost_check_top_test
// fills a corner of the cost map, runs directed and random motion primitive
// actions through several map sizes and thresholds with bursty input and a
// stalling result side, and leaves the checking to lacc_cost_checker
// ----------------------------------------------------------------------------
module lattice_action_cost_check_top_test;
  import lacc_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned PHASE_WORDS   = 100;
  // random actions only touch cells of this corner window or cells off the map
  localparam int unsigned WIN           = 16;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  map_x;
    logic [7:0]  map_y;
    logic [7:0]  cell_value;
    logic [7:0]  end_dx;
    logic [7:0]  end_dy;
    logic [7:0]  step_dx;
    logic [7:0]  step_dy;
    logic        step_present;
    logic [15:0] base_cost;
    logic        last;
  } word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [7:0]  in_map_x;
  logic [7:0]  in_map_y;
  logic [7:0]  in_cell_value;
  logic [7:0]  in_end_dx;
  logic [7:0]  in_end_dy;
  logic [7:0]  in_step_dx;
  logic [7:0]  in_step_dy;
  logic        in_step_present;
  logic [15:0] in_base_cost;
  logic        in_last;
  logic        out_valid;
  logic        out_stall;
  logic [23:0] out_action_cost;
  logic        out_blocked;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results;
  int unsigned blocked_results;

  int unsigned burst_left;
  int unsigned words_sent;
  int unsigned settings_used;
  int unsigned idle_cycles;
  int unsigned cur_w;
  int unsigned cur_h;
  int unsigned cur_insc;
  bit          action_open;

  lattice_action_cost_check_top i_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .in_command_i      (in_command),
    .in_map_x_i        (in_map_x),
    .in_map_y_i        (in_map_y),
    .in_cell_value_i   (in_cell_value),
    .in_end_dx_i       (in_end_dx),
    .in_end_dy_i       (in_end_dy),
    .in_step_dx_i      (in_step_dx),
    .in_step_dy_i      (in_step_dy),
    .in_step_present_i (in_step_present),
    .in_base_cost_i    (in_base_cost),
    .in_last_i         (in_last),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .out_action_cost_o (out_action_cost),
    .out_blocked_o     (out_blocked),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  lacc_cost_checker i_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .in_command_i      (in_command),
    .in_map_x_i        (in_map_x),
    .in_map_y_i        (in_map_y),
    .in_cell_value_i   (in_cell_value),
    .in_end_dx_i       (in_end_dx),
    .in_end_dy_i       (in_end_dy),
    .in_step_dx_i      (in_step_dx),
    .in_step_dy_i      (in_step_dy),
    .in_step_present_i (in_step_present),
    .in_base_cost_i    (in_base_cost),
    .in_last_i         (in_last),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .out_action_cost_i (out_action_cost),
    .out_blocked_i     (out_blocked),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .results_o         (results),
    .blocked_o         (blocked_results)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side stalls in modes of random length: never, half, mostly
  initial begin
    int unsigned mode;
    out_stall = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(32, 256)) begin
        @(negedge clk);
        case (mode)
          0:       out_stall = 1'b0;
          1:       out_stall = 1'($urandom_range(0, 1));
          default: out_stall = ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%t no word moved for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, pending);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic word_t write_word(logic [7:0] x, logic [7:0] y, logic [7:0] v);
    word_t w;
    w = word_t'({$urandom, $urandom, $urandom});
    w.command    = CMD_WRITE;
    w.map_x      = x;
    w.map_y      = y;
    w.cell_value = v;
    return w;
  endfunction

  function automatic word_t eval_word(logic [7:0] x, logic [7:0] y,
                                      logic [7:0] edx, logic [7:0] edy,
                                      logic [7:0] sdx, logic [7:0] sdy,
                                      logic present, logic [15:0] base, logic last);
    word_t w;
    w = word_t'({$urandom, $urandom, $urandom});
    w.command      = CMD_EVAL;
    w.map_x        = x;
    w.map_y        = y;
    w.end_dx       = edx;
    w.end_dy       = edy;
    w.step_dx      = sdx;
    w.step_dy      = sdy;
    w.step_present = present;
    w.base_cost    = base;
    w.last         = last;
    return w;
  endfunction

  // coordinate inside the window, or now and then one off the map
  function automatic logic [7:0] pick_coord(int unsigned dim);
    int unsigned lim;
    lim = (dim > 256) ? 256 : dim;
    if (lim < 256 && $urandom_range(0, 7) == 0) return 8'($urandom_range(lim, 255));
    return 8'($urandom_range(0, WIN - 1));
  endfunction

  // offset whose cell lies inside the window or off the map
  function automatic logic [7:0] safe_offset(logic [7:0] src, int unsigned dim);
    int unsigned lim;
    int          pos;
    logic [7:0]  d;
    lim = (dim > 256) ? 256 : dim;
    repeat (8) begin
      d   = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(int'($urandom_range(0, 8)) - 4);
      pos = int'(src) + int'($signed(d));
      if (pos < int'(WIN) || pos >= int'(lim)) return d;
    end
    return (src <= 8'd128) ? 8'(-int'(src)) : 8'd127;
  endfunction

  function automatic word_t noise_word();
    word_t w;
    w = word_t'({$urandom, $urandom, $urandom});
    w.command = CMD_EVAL;
    w.map_x   = pick_coord(cur_w);
    w.map_y   = pick_coord(cur_h);
    w.end_dx  = safe_offset(w.map_x, cur_w);
    w.end_dy  = safe_offset(w.map_y, cur_h);
    w.step_dx = safe_offset(w.map_x, cur_w);
    w.step_dy = safe_offset(w.map_y, cur_h);
    return w;
  endfunction

  function automatic logic [7:0] cell_cost();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return 8'($urandom_range(0, 40));
    if (pick < 8) return 8'(int'(cur_insc) + int'($urandom_range(0, 2)) - 1);
    return 8'($urandom);
  endfunction

  task automatic push_word(input word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_command      = w.command;
    in_map_x        = w.map_x;
    in_map_y        = w.map_y;
    in_cell_value   = w.cell_value;
    in_end_dx       = w.end_dx;
    in_end_dy       = w.end_dy;
    in_step_dx      = w.step_dx;
    in_step_dy      = w.step_dy;
    in_step_present = w.step_present;
    in_base_cost    = w.base_cost;
    in_last         = w.last;
    in_valid        = 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    words_sent++;
    if (w.command == CMD_EVAL) action_open = !w.last;
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [8:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input int unsigned w, input int unsigned h,
                                input int unsigned insc, input int unsigned obst);
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_MAP_WIDTH, 9'(w));
    write_reg(REG_MAP_HEIGHT, 9'(h));
    write_reg(REG_INSCRIBED, 9'(insc));
    write_reg(REG_OBSTACLE, 9'(obst));
    @(negedge clk);
    cfg_valid = 1'b0;
    cur_w     = w;
    cur_h     = h;
    cur_insc  = insc;
    settings_used++;
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned sent;
    int unsigned steps;
    int unsigned items;
    int unsigned k;
    int unsigned pick;
    logic [7:0]  sx, sy, edx, edy;
    logic [7:0]  cx, cy;
    logic [15:0] base;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        push_word(write_word(pick_coord(cur_w), pick_coord(cur_h), cell_cost()));
        sent++;
      end else if (pick < 30) begin
        push_word(noise_word());
        sent++;
      end else begin
        sx    = pick_coord(cur_w);
        sy    = pick_coord(cur_h);
        edx   = safe_offset(sx, cur_w);
        edy   = safe_offset(sy, cur_h);
        base  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
        steps = $urandom_range(0, 4);
        items = (steps == 0) ? 1 : steps;
        for (k = 0; k < items; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            push_word(write_word(pick_coord(cur_w), pick_coord(cur_h), cell_cost()));
            sent++;
          end
          if ($urandom_range(0, 19) == 0) begin
            sx  = pick_coord(cur_w);
            edx = safe_offset(sx, cur_w);
          end
          push_word(eval_word(sx, sy, edx, edy, safe_offset(sx, cur_w),
                              safe_offset(sy, cur_h), steps != 0, base, k == items - 1));
          sent++;
        end
      end
    end
    if (action_open) begin
      cx = pick_coord(cur_w);
      cy = pick_coord(cur_h);
      push_word(eval_word(cx, cy, safe_offset(cx, cur_w), safe_offset(cy, cur_h),
                          safe_offset(cx, cur_w), safe_offset(cy, cur_h),
                          1'($urandom_range(0, 1)), 16'($urandom), 1'b1));
    end
  endtask

  initial begin
    int unsigned a;
    in_valid        = 1'b0;
    in_command      = CMD_WRITE;
    in_map_x        = '0;
    in_map_y        = '0;
    in_cell_value   = '0;
    in_end_dx       = '0;
    in_end_dy       = '0;
    in_step_dx      = '0;
    in_step_dy      = '0;
    in_step_present = 1'b0;
    in_base_cost    = '0;
    in_last         = 1'b0;
    cfg_valid       = 1'b0;
    cfg_index       = REG_MAP_WIDTH;
    cfg_data        = '0;
    burst_left      = 0;
    words_sent      = 0;
    settings_used   = 1;
    idle_cycles     = 0;
    action_open     = 1'b0;
    cur_w           = 256;
    cur_h           = 256;
    cur_insc        = 253;
    rst_n           = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // every window cell gets a value before any action can read it
    burst_left = WIN * WIN;
    for (a = 0; a < WIN * WIN; a++) begin
      push_word(write_word(8'(a % WIN), 8'(a / WIN), cell_cost()));
    end
    burst_left = 0;

    push_word(write_word(8'd10, 8'd10, 8'd5));
    push_word(write_word(8'd12, 8'd11, 8'd100));
    push_word(write_word(8'd11, 8'd10, 8'd252));
    push_word(write_word(8'd20, 8'd20, 8'd253));
    push_word(write_word(8'd0, 8'd0, 8'd0));
    push_word(write_word(8'd255, 8'd255, 8'd255));
    push_word(write_word(8'd127, 8'd127, 8'd30));
    // empty action, full base cost
    push_word(eval_word(8'd10, 8'd10, 8'd2, 8'd1, 8'd0, 8'd0, 1'b0, 16'hFFFF, 1'b1));
    // three cells with a map write inside the open action
    push_word(eval_word(8'd10, 8'd10, 8'd2, 8'd1, 8'd1, 8'd0, 1'b1, 16'hFFFF, 1'b0));
    push_word(eval_word(8'd10, 8'd10, 8'd2, 8'd1, 8'd0, 8'd0, 1'b1, 16'hFFFF, 1'b0));
    push_word(write_word(8'd0, 8'd0, 8'd0));
    push_word(eval_word(8'd10, 8'd10, 8'd2, 8'd1, 8'd2, 8'd1, 1'b1, 16'hFFFF, 1'b1));
    // step reaches inscribed, end at inscribed, source at obstacle
    push_word(eval_word(8'd10, 8'd10, 8'd2, 8'd1, 8'd10, 8'd10, 1'b1, 16'd7, 1'b1));
    push_word(eval_word(8'd10, 8'd10, 8'd10, 8'd10, 8'd0, 8'd0, 1'b0, 16'd7, 1'b1));
    push_word(eval_word(8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'd7, 1'b1));
    // end off the map, far end inside, step off the map
    push_word(eval_word(8'd0, 8'd0, 8'h80, 8'h80, 8'd0, 8'd0, 1'b0, 16'd3, 1'b1));
    push_word(eval_word(8'd0, 8'd0, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 1'b1, 16'd3, 1'b1));
    push_word(eval_word(8'd0, 8'd0, 8'd0, 8'd0, 8'hFF, 8'd0, 1'b1, 16'd3, 1'b1));
    // zero base cost
    push_word(eval_word(8'd10, 8'd10, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 16'd0, 1'b1));

    run_random(PHASE_WORDS);
    apply_settings(16, 12, 200, 230);
    run_random(PHASE_WORDS);
    apply_settings(0, 256, 253, 254);
    run_random(PHASE_WORDS / 2);
    apply_settings(511, 300, 255, 255);
    run_random(PHASE_WORDS);
    apply_settings(1, 1, 128, 128);
    run_random(PHASE_WORDS);
    apply_settings(40, 256, 0, 0);
    run_random(PHASE_WORDS / 2);
    apply_settings(256, 256, 90, 60);
    run_random(PHASE_WORDS);
    apply_settings($urandom_range(1, 256), $urandom_range(1, 256),
                   $urandom_range(0, 255), $urandom_range(0, 255));
    run_random(PHASE_WORDS);
    apply_settings(256, 256, 253, 254);
    run_random(PHASE_WORDS);

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("sent %0d input words over %0d register settings", words_sent, settings_used);
    $display("checked %0d action results, %0d of them blocked", results, blocked_results);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
